>>> rtl/core/lru_page_replacement_macros.svh
// Assertion macros for the LRU page replacement block.
// Uses the clk_i / rst_ni names of the including module; empty when SYNTH is set.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

`ifndef SYNTH
`define LRUPR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LRUPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRUPR_ASSERT_IMP(name, ante, cons, msg)
`define LRUPR_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

>>> rtl/core/lrupr_pkg.sv
// Shared constants for the LRU page replacement block.
// No dependencies.
package lrupr_pkg;

  localparam int MAX_FRAMES_DEF = 32;
  localparam int PAGE_BITS_DEF  = 5;
  localparam int AGE_BITS_DEF   = 16;

  localparam int CFG_W  = 6;
  localparam int MISS_W = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

endpackage

>>> rtl/core/lrupr_ram.sv
// Frame store: tag and age per frame, one write and one registered read port.
// No package dependencies.
module lrupr_ram #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5,
  parameter int DW    = 21
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [DW-1:0]    rdata_o,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [DW-1:0]    wdata_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/lrupr_engine.sv
// Sweep engine: ages frames, finds hit / empty / oldest, writes back the chosen frame.
// Depends on lrupr_pkg, lrupr_ram and the assertion macro header.
module lrupr_engine import lrupr_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int AGE_BITS   = AGE_BITS_DEF,
  parameter int IDX_W      = 5,
  parameter int CNT_W      = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [CFG_W-1:0]     frames_cfg_i,
  output logic                 idle_o,
  output logic                 done_o,
  input  logic                 ack_i,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     frame_o,
  output logic [MISS_W-1:0]    miss_o
);

  localparam int DW = PAGE_BITS + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AgeMax  = {AGE_BITS{1'b1}};
  localparam logic [MISS_W-1:0]   MissMax = {MISS_W{1'b1}};
  localparam logic [CFG_W:0]      MaxCnt  = (CFG_W+1)'(MAX_FRAMES);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FINAL, S_DONE} state_e;

  state_e                state_q, state_d;
  logic [PAGE_BITS-1:0]  page_q, page_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  match_q, match_d;
  logic [IDX_W-1:0]      match_idx_q, match_idx_d;
  logic                  empty_q, empty_d;
  logic [IDX_W-1:0]      empty_idx_q, empty_idx_d;
  logic [AGE_BITS-1:0]   best_age_q, best_age_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [MAX_FRAMES-1:0] valid_q, valid_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      frame_q, frame_d;
  logic [MISS_W-1:0]     miss_q, miss_d;

  logic                  ram_re, ram_we;
  logic [IDX_W-1:0]      ram_raddr, ram_waddr;
  logic [DW-1:0]         ram_rdata, ram_wdata;

  logic [PAGE_BITS-1:0]  rd_tag;
  logic [AGE_BITS-1:0]   rd_age, age_inc, cand_age;
  logic                  rd_valid;
  logic [CFG_W:0]        cfg_ext, n_sel;
  logic [IDX_W-1:0]      chosen;

  lrupr_ram #(
    .DEPTH(MAX_FRAMES),
    .IDX_W(IDX_W),
    .DW   (DW)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata)
  );

  assign rd_tag   = ram_rdata[DW-1:AGE_BITS];
  assign rd_age   = ram_rdata[AGE_BITS-1:0];
  assign rd_valid = valid_q[rd_idx_q];
  assign age_inc  = (rd_age == AgeMax) ? rd_age : rd_age + AGE_BITS'(1);
  assign cand_age = rd_valid ? age_inc : '0;

  // zero counts as one, oversize clamps to the frame count
  assign cfg_ext = {1'b0, frames_cfg_i};
  assign n_sel   = (cfg_ext == '0) ? (CFG_W+1)'(1) :
                   ((cfg_ext > MaxCnt) ? MaxCnt : cfg_ext);

  assign chosen = match_q ? match_idx_q : (empty_q ? empty_idx_q : best_idx_q);

  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    n_d         = n_q;
    k_d         = k_q;
    pend_d      = pend_q;
    rd_idx_d    = rd_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    best_age_d  = best_age_q;
    best_idx_d  = best_idx_q;
    valid_d     = valid_q;
    hit_d       = hit_q;
    frame_d     = frame_q;
    miss_d      = miss_q;
    ram_re      = 1'b0;
    ram_raddr   = k_q[IDX_W-1:0];
    ram_we      = 1'b0;
    ram_waddr   = rd_idx_q;
    ram_wdata   = {rd_tag, age_inc};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SWEEP;
          page_d  = page_i;
          n_d     = CNT_W'(n_sel);
          k_d     = '0;
          match_d = 1'b0;
          empty_d = 1'b0;
        end
      end
      S_SWEEP: begin
        if (k_q < n_q) begin
          ram_re   = 1'b1;
          k_d      = k_q + CNT_W'(1);
          pend_d   = 1'b1;
          rd_idx_d = k_q[IDX_W-1:0];
        end else begin
          pend_d  = 1'b0;
          state_d = S_FINAL;
        end
        if (pend_q) begin
          ram_we = rd_valid;
          if (rd_valid && !match_q && (rd_tag == page_q)) begin
            match_d     = 1'b1;
            match_idx_d = rd_idx_q;
          end
          if (!rd_valid && !empty_q) begin
            empty_d     = 1'b1;
            empty_idx_d = rd_idx_q;
          end
          if ((rd_idx_q == '0) || (cand_age > best_age_q)) begin
            best_age_d = cand_age;
            best_idx_d = rd_idx_q;
          end
        end
      end
      S_FINAL: begin
        ram_we          = 1'b1;
        ram_waddr       = chosen;
        ram_wdata       = {page_q, {AGE_BITS{1'b0}}};
        valid_d[chosen] = 1'b1;
        hit_d           = match_q;
        frame_d         = chosen;
        if (!match_q && (miss_q != MissMax)) begin
          miss_d = miss_q + MISS_W'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      page_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      rd_idx_q    <= '0;
      match_q     <= 1'b0;
      match_idx_q <= '0;
      empty_q     <= 1'b0;
      empty_idx_q <= '0;
      best_age_q  <= '0;
      best_idx_q  <= '0;
      valid_q     <= '0;
      hit_q       <= 1'b0;
      frame_q     <= '0;
      miss_q      <= '0;
    end else begin
      state_q     <= state_d;
      page_q      <= page_d;
      n_q         <= n_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      rd_idx_q    <= rd_idx_d;
      match_q     <= match_d;
      match_idx_q <= match_idx_d;
      empty_q     <= empty_d;
      empty_idx_q <= empty_idx_d;
      best_age_q  <= best_age_d;
      best_idx_q  <= best_idx_d;
      valid_q     <= valid_d;
      hit_q       <= hit_d;
      frame_q     <= frame_d;
      miss_q      <= miss_d;
    end
  end

  assign idle_o  = (state_q == S_IDLE);
  assign done_o  = (state_q == S_DONE);
  assign hit_o   = hit_q;
  assign frame_o = frame_q;
  assign miss_o  = miss_q;

`include "lru_page_replacement_macros.svh"

  `LRUPR_ASSERT_IMP(a_done_frame_valid, state_q == S_DONE, valid_q[frame_q], "frame not valid")
  `LRUPR_ASSERT_NEXT(a_miss_monotone, 1'b1, miss_q >= $past(miss_q), "miss count fell")
  `LRUPR_ASSERT_IMP(a_sweep_bound, state_q == S_SWEEP, (k_q <= n_q) && (n_q != '0), "bad sweep")
  `LRUPR_ASSERT_NEXT(a_hit_keeps_miss, state_q == S_FINAL && match_q, miss_q == $past(miss_q),
                     "miss count moved on hit")

endmodule

>>> rtl/core/lru_page_replacement.sv
// Top level of the LRU page replacement block: handshakes, config register, result register.
// Depends on lrupr_pkg and lrupr_engine.
//
//   channel | signals                               | dir
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i  | in
//   in      | in_valid_i, in_ready_o, page_number_i | in
//   out     | out_valid_o, out_ready_i, hit_o, ...  | out
//
// n is the active frame count. The frame RAM is swept one entry a cycle through
// its single read port, over the first n entries; after the last registered read
// returns, the chosen frame is written back.
// One item is in the engine at a time. A finished result waits in the output
// register while the next item is taken, and an unread result stalls the engine.
// Reset clears the frame valid flags at once; there is no clearing pass.
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int AGE_BITS   = AGE_BITS_DEF,
  parameter int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PAGE_BITS-1:0] page_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic [IDX_W-1:0]     frame_index_o,
  output logic [MISS_W-1:0]    miss_total_o
);

  logic [CFG_W-1:0]  frames_q;
  logic              out_valid_q, out_valid_d;
  logic              hit_q;
  logic [IDX_W-1:0]  frame_q;
  logic [MISS_W-1:0] miss_q;

  logic              eng_idle, eng_done, eng_ack, eng_hit;
  logic [IDX_W-1:0]  eng_frame;
  logic [MISS_W-1:0] eng_miss;

  lrupr_engine #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .AGE_BITS  (AGE_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && in_ready_o),
    .page_i      (page_number_i),
    .frames_cfg_i(frames_q),
    .idle_o      (eng_idle),
    .done_o      (eng_done),
    .ack_i       (eng_ack),
    .hit_o       (eng_hit),
    .frame_o     (eng_frame),
    .miss_o      (eng_miss)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = eng_idle;
  assign eng_ack     = eng_done && (!out_valid_q || out_ready_i);
  assign out_valid_d = eng_ack || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= CFG_RESET;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      frame_q     <= '0;
      miss_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        frames_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
      if (eng_ack) begin
        hit_q   <= eng_hit;
        frame_q <= eng_frame;
        miss_q  <= eng_miss;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign frame_index_o = frame_q;
  assign miss_total_o  = miss_q;

endmodule
